// ===== sv/amrf_pkg.sv =====
// ----------------------------------------------------------------------------
// amrf_pkg
// Shared types and register map of the mixer index/data register file.
// ----------------------------------------------------------------------------
`default_nettype none

package amrf_pkg;

	localparam int unsigned BYTE_W = 8;

	typedef logic [BYTE_W-1:0] byte_t;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic PORT_INDEX = 1'b0;
	localparam logic PORT_DATA  = 1'b1;

	// register map
	localparam byte_t ADDR_RESET     = 8'h00;
	localparam byte_t ADDR_PK_DAC    = 8'h04;
	localparam byte_t ADDR_PK_MASTER = 8'h22;
	localparam byte_t ADDR_PK_FM     = 8'h26;
	localparam byte_t ADDR_PK_CD     = 8'h28;
	localparam byte_t ADDR_PK_LINE   = 8'h2e;
	localparam byte_t ADDR_MASTER_L  = 8'h30;
	localparam byte_t ADDR_MASTER_R  = 8'h31;
	localparam byte_t ADDR_DAC_L     = 8'h32;
	localparam byte_t ADDR_DAC_R     = 8'h33;
	localparam byte_t ADDR_FM_L      = 8'h34;
	localparam byte_t ADDR_FM_R      = 8'h35;
	localparam byte_t ADDR_CD_L      = 8'h36;
	localparam byte_t ADDR_CD_R      = 8'h37;
	localparam byte_t ADDR_LINE_L    = 8'h38;
	localparam byte_t ADDR_LINE_R    = 8'h39;
	localparam byte_t ADDR_MIC       = 8'h3a;
	localparam byte_t ADDR_SPEAKER   = 8'h3b;
	localparam byte_t ADDR_OUT_SW    = 8'h3c;
	localparam byte_t ADDR_IN_SW_L   = 8'h3d;
	localparam byte_t ADDR_IN_SW_R   = 8'h3e;
	localparam byte_t ADDR_IN_GAIN_L = 8'h3f;
	localparam byte_t ADDR_IN_GAIN_R = 8'h40;
	localparam byte_t ADDR_OUT_GN_L  = 8'h41;
	localparam byte_t ADDR_OUT_GN_R  = 8'h42;
	localparam byte_t ADDR_AGC       = 8'h43;
	localparam byte_t ADDR_TREBLE_L  = 8'h44;
	localparam byte_t ADDR_TREBLE_R  = 8'h45;
	localparam byte_t ADDR_BASS_L    = 8'h46;
	localparam byte_t ADDR_BASS_R    = 8'h47;
	localparam byte_t ADDR_ID0       = 8'h80;
	localparam byte_t ADDR_ID1       = 8'h81;
	localparam byte_t ADDR_IRQ       = 8'h82;

	localparam byte_t ID0_VALUE = 8'h12;
	localparam byte_t ID1_VALUE = 8'h22;

	typedef struct packed {
		logic  op;
		logic  port;
		byte_t wdata;
		byte_t irq_status;
	} req_t;

	typedef struct packed {
		byte_t rdata;
	} rsp_t;

	// one access handed from the input stage to the register store
	typedef struct packed {
		logic  en;
		logic  wr;
		logic  port;
		byte_t wdata;
		byte_t irq;
	} acc_t;

endpackage

`default_nettype wire

// ===== sv/amrf_req_if.sv =====
// ----------------------------------------------------------------------------
// amrf_req_if
// Request channel: valid, ready and one register access.
// ----------------------------------------------------------------------------
`default_nettype none

interface amrf_req_if;
	import amrf_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/amrf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// amrf_rsp_if
// Response channel: valid, ready and the read data byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface amrf_rsp_if;
	import amrf_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/amrf_regs.sv =====
// ----------------------------------------------------------------------------
// amrf_regs
// Index register and mixer register store with read mux and write decode.
// ----------------------------------------------------------------------------
`default_nettype none

module amrf_regs (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire amrf_pkg::acc_t acc,
	output      amrf_pkg::byte_t rdata
);
	import amrf_pkg::*;

	// levels keep only the bits a write can set
	typedef struct packed {
		logic [4:0] master_l;
		logic [4:0] master_r;
		logic [4:0] dac_l;
		logic [4:0] dac_r;
		logic [4:0] fm_l;
		logic [4:0] fm_r;
		logic [4:0] cd_l;
		logic [4:0] cd_r;
		logic [4:0] line_l;
		logic [4:0] line_r;
		logic [4:0] mic;
		logic [1:0] speaker;
		logic [4:0] out_sw;
		logic [6:0] in_sw_l;
		logic [6:0] in_sw_r;
		logic [1:0] in_gain_l;
		logic [1:0] in_gain_r;
		logic [1:0] out_gain_l;
		logic [1:0] out_gain_r;
		logic       agc;
		logic [3:0] treble_l;
		logic [3:0] treble_r;
		logic [3:0] bass_l;
		logic [3:0] bass_r;
	} mix_t;

	localparam mix_t MIX_RESET = '{
		master_l:   5'h18, master_r: 5'h18,
		dac_l:      5'h18, dac_r:    5'h18,
		fm_l:       5'h18, fm_r:     5'h18,
		cd_l:       5'h18, cd_r:     5'h18,
		line_l:     5'h00, line_r:   5'h00,
		mic:        5'h00,
		speaker:    2'h2,
		out_sw:     5'h1f,
		in_sw_l:    7'h15, in_sw_r:  7'h0b,
		in_gain_l:  2'h0, in_gain_r:  2'h0,
		out_gain_l: 2'h0, out_gain_r: 2'h0,
		agc:        1'b0,
		treble_l:   4'h8, treble_r: 4'h8,
		bass_l:     4'h8, bass_r:   4'h8
	};

	byte_t index_q;
	mix_t  mix_q;

	logic [4:0] pk_hi;
	logic [4:0] pk_lo;
	byte_t      d;

	assign d = acc.wdata;
	// packed alias writes each nibble as nibble << 4 | 8
	assign pk_hi = {d[7:4], 1'b1};
	assign pk_lo = {d[3:0], 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			mix_q   <= MIX_RESET;
		end else if (acc.en && acc.wr) begin
			if (acc.port == PORT_INDEX) begin
				index_q <= d;
			end else begin
				case (index_q)
					ADDR_RESET: begin
						if (!d[0]) mix_q <= MIX_RESET;
					end
					ADDR_PK_DAC: begin
						mix_q.dac_l <= pk_hi;
						mix_q.dac_r <= pk_lo;
					end
					ADDR_PK_MASTER: begin
						mix_q.master_l <= pk_hi;
						mix_q.master_r <= pk_lo;
					end
					ADDR_PK_FM: begin
						mix_q.fm_l <= pk_hi;
						mix_q.fm_r <= pk_lo;
					end
					ADDR_PK_CD: begin
						mix_q.cd_l <= pk_hi;
						mix_q.cd_r <= pk_lo;
					end
					ADDR_PK_LINE: begin
						mix_q.line_l <= pk_hi;
						mix_q.line_r <= pk_lo;
					end
					ADDR_MASTER_L:  mix_q.master_l   <= d[7:3];
					ADDR_MASTER_R:  mix_q.master_r   <= d[7:3];
					ADDR_DAC_L:     mix_q.dac_l      <= d[7:3];
					ADDR_DAC_R:     mix_q.dac_r      <= d[7:3];
					ADDR_FM_L:      mix_q.fm_l       <= d[7:3];
					ADDR_FM_R:      mix_q.fm_r       <= d[7:3];
					ADDR_CD_L:      mix_q.cd_l       <= d[7:3];
					ADDR_CD_R:      mix_q.cd_r       <= d[7:3];
					ADDR_LINE_L:    mix_q.line_l     <= d[7:3];
					ADDR_LINE_R:    mix_q.line_r     <= d[7:3];
					ADDR_MIC:       mix_q.mic        <= d[7:3];
					ADDR_SPEAKER:   mix_q.speaker    <= d[7:6];
					ADDR_OUT_SW:    mix_q.out_sw     <= d[4:0];
					ADDR_IN_SW_L:   mix_q.in_sw_l    <= d[6:0];
					ADDR_IN_SW_R:   mix_q.in_sw_r    <= d[6:0];
					ADDR_IN_GAIN_L: mix_q.in_gain_l  <= d[7:6];
					ADDR_IN_GAIN_R: mix_q.in_gain_r  <= d[7:6];
					ADDR_OUT_GN_L:  mix_q.out_gain_l <= d[7:6];
					ADDR_OUT_GN_R:  mix_q.out_gain_r <= d[7:6];
					ADDR_AGC:       mix_q.agc        <= d[0];
					ADDR_TREBLE_L:  mix_q.treble_l   <= d[7:4];
					ADDR_TREBLE_R:  mix_q.treble_r   <= d[7:4];
					ADDR_BASS_L:    mix_q.bass_l     <= d[7:4];
					ADDR_BASS_R:    mix_q.bass_r     <= d[7:4];
					default: ;
				endcase
			end
		end
	end

	byte_t reg_rd;

	always_comb begin
		case (index_q)
			ADDR_PK_DAC:    reg_rd = {mix_q.dac_l[4:1], mix_q.dac_r[4:1]};
			ADDR_PK_MASTER: reg_rd = {mix_q.master_l[4:1], mix_q.master_r[4:1]};
			ADDR_PK_FM:     reg_rd = {mix_q.fm_l[4:1], mix_q.fm_r[4:1]};
			ADDR_PK_CD:     reg_rd = {mix_q.cd_l[4:1], mix_q.cd_r[4:1]};
			ADDR_PK_LINE:   reg_rd = {mix_q.line_l[4:1], mix_q.line_r[4:1]};
			ADDR_MASTER_L:  reg_rd = {mix_q.master_l, 3'b000};
			ADDR_MASTER_R:  reg_rd = {mix_q.master_r, 3'b000};
			ADDR_DAC_L:     reg_rd = {mix_q.dac_l, 3'b000};
			ADDR_DAC_R:     reg_rd = {mix_q.dac_r, 3'b000};
			ADDR_FM_L:      reg_rd = {mix_q.fm_l, 3'b000};
			ADDR_FM_R:      reg_rd = {mix_q.fm_r, 3'b000};
			ADDR_CD_L:      reg_rd = {mix_q.cd_l, 3'b000};
			ADDR_CD_R:      reg_rd = {mix_q.cd_r, 3'b000};
			ADDR_LINE_L:    reg_rd = {mix_q.line_l, 3'b000};
			ADDR_LINE_R:    reg_rd = {mix_q.line_r, 3'b000};
			ADDR_MIC:       reg_rd = {mix_q.mic, 3'b000};
			ADDR_SPEAKER:   reg_rd = {mix_q.speaker, 6'b000000};
			ADDR_OUT_SW:    reg_rd = {3'b000, mix_q.out_sw};
			ADDR_IN_SW_L:   reg_rd = {1'b0, mix_q.in_sw_l};
			ADDR_IN_SW_R:   reg_rd = {1'b0, mix_q.in_sw_r};
			ADDR_IN_GAIN_L: reg_rd = {mix_q.in_gain_l, 6'b000000};
			ADDR_IN_GAIN_R: reg_rd = {mix_q.in_gain_r, 6'b000000};
			ADDR_OUT_GN_L:  reg_rd = {mix_q.out_gain_l, 6'b000000};
			ADDR_OUT_GN_R:  reg_rd = {mix_q.out_gain_r, 6'b000000};
			ADDR_AGC:       reg_rd = {7'b0000000, mix_q.agc};
			ADDR_TREBLE_L:  reg_rd = {mix_q.treble_l, 4'b0000};
			ADDR_TREBLE_R:  reg_rd = {mix_q.treble_r, 4'b0000};
			ADDR_BASS_L:    reg_rd = {mix_q.bass_l, 4'b0000};
			ADDR_BASS_R:    reg_rd = {mix_q.bass_r, 4'b0000};
			ADDR_ID0:       reg_rd = ID0_VALUE;
			ADDR_ID1:       reg_rd = ID1_VALUE;
			ADDR_IRQ:       reg_rd = acc.irq;
			default:        reg_rd = '0;
		endcase
	end

	// writes return zero
	always_comb begin
		if (acc.wr == OP_WRITE) begin
			rdata = '0;
		end else if (acc.port == PORT_INDEX) begin
			rdata = index_q;
		end else begin
			rdata = reg_rd;
		end
	end

endmodule

`default_nettype wire

// ===== sv/audio_mixer_register_file_core.sv =====
// ----------------------------------------------------------------------------
// audio_mixer_register_file_core
// Index/data register pair of a stereo audio mixer.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | role
//  req     | in  | op, port, wdata, irq_status      | one register access
//  rsp     | out | rdata                            | read byte, zero on writes
//
//  one request per clock unless rsp.ready stalls; input register, then result register
//  the register store is read and written in the cycle the request leaves the
//  input register, so each request sees the writes of all earlier ones
//  arst_n clears the index and loads the mixer defaults at once
//  rsp.ready low holds the result; the input register takes one more request,
//  then req.ready drops until the result is taken
// ----------------------------------------------------------------------------
`default_nettype none

module audio_mixer_register_file_core (
	input wire logic clk,
	input wire logic arst_n,
	amrf_req_if.sink req,
	amrf_rsp_if.source rsp
);
	import amrf_pkg::*;

	req_t  req_s1;
	logic  valid_s1;
	byte_t rdata_q;
	logic  out_valid_q;
	logic  adv;
	acc_t  acc;
	byte_t rd;

	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	assign acc.en    = adv;
	assign acc.wr    = req_s1.op;
	assign acc.port  = req_s1.port;
	assign acc.wdata = req_s1.wdata;
	assign acc.irq   = req_s1.irq_status;

	amrf_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.rdata  (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.ready) valid_s1 <= req.valid;
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) req_s1 <= req.data;
		if (adv) rdata_q <= rd;
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.data.rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/amrf_chk.sv =====
// ----------------------------------------------------------------------------
// amrf_chk
// Port-level checks of the mixer register file, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module amrf_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire amrf_pkg::rsp_t rsp_data
);
	import amrf_pkg::*;

	// requests taken but not yet answered
	logic [1:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (rsp_acc && !req_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without a pending request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more requests in flight than stages");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready && pend_q == 2'd2)
		else $error("request side stalled without a full pipeline");

endmodule

bind audio_mixer_register_file_core amrf_chk u_amrf_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mixer index/data register file. Requests go in
// as directed access sequences, then as random index/data traffic, while
// both channels idle and stall. Each request is predicted on acceptance and
// every result is compared in order against the predicted read byte.
// ----------------------------------------------------------------------------

module tb;
	import amrf_pkg::*;

	localparam int unsigned RESET_CYCLES  = 12;
	localparam int unsigned IDLE_LIMIT    = 3000;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned MAX_PRINTS    = 100;
	localparam int unsigned RANDOM_ITEMS  = 1180;
	localparam int unsigned HELD_ITEMS    = 40;
	localparam int unsigned PHASE_ITEMS   = 150;

	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

	logic clk;
	logic arst_n;

	amrf_req_if req_ch();
	amrf_rsp_if rsp_ch();

	audio_mixer_register_file_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// predicted register contents
	byte_t      sel_index;
	byte_t      vol_master [2];
	byte_t      vol_dac [2];
	byte_t      vol_fm [2];
	byte_t      vol_cd [2];
	byte_t      vol_line [2];
	byte_t      vol_mic;
	byte_t      vol_spk;
	logic [4:0] out_mix_sw;
	logic [6:0] in_mix_sw [2];
	byte_t      in_amp [2];
	byte_t      out_amp [2];
	logic       agc_bit;
	byte_t      tone_treble [2];
	byte_t      tone_bass [2];

	byte_t expected_rdata [$];

	int unsigned errors = 0;
	int unsigned n_requests = 0;
	int unsigned n_reads = 0;
	int unsigned n_results = 0;
	int unsigned n_restores = 0;
	int unsigned idle_cycles = 0;
	int unsigned rx_tick = 0;
	int unsigned burst_left = 0;
	int unsigned gap_max = 0;
	rx_mode_t    rx_mode = RX_ALWAYS;
	bit          hold_off = 1'b0;

	byte_t known_addrs [33] = '{
		ADDR_RESET, ADDR_PK_DAC, ADDR_PK_MASTER, ADDR_PK_FM, ADDR_PK_CD, ADDR_PK_LINE,
		ADDR_MASTER_L, ADDR_MASTER_R, ADDR_DAC_L, ADDR_DAC_R, ADDR_FM_L, ADDR_FM_R,
		ADDR_CD_L, ADDR_CD_R, ADDR_LINE_L, ADDR_LINE_R, ADDR_MIC, ADDR_SPEAKER,
		ADDR_OUT_SW, ADDR_IN_SW_L, ADDR_IN_SW_R, ADDR_IN_GAIN_L, ADDR_IN_GAIN_R,
		ADDR_OUT_GN_L, ADDR_OUT_GN_R, ADDR_AGC, ADDR_TREBLE_L, ADDR_TREBLE_R,
		ADDR_BASS_L, ADDR_BASS_R, ADDR_ID0, ADDR_ID1, ADDR_IRQ
	};

	function automatic void load_mixer_defaults();
		vol_master  = '{8'hc0, 8'hc0};
		vol_dac     = '{8'hc0, 8'hc0};
		vol_fm      = '{8'hc0, 8'hc0};
		vol_cd      = '{8'hc0, 8'hc0};
		vol_line    = '{8'h00, 8'h00};
		vol_mic     = 8'h00;
		vol_spk     = 8'h80;
		out_mix_sw  = 5'h1f;
		in_mix_sw   = '{7'h15, 7'h0b};
		in_amp      = '{8'h00, 8'h00};
		out_amp     = '{8'h00, 8'h00};
		agc_bit     = 1'b0;
		tone_treble = '{8'h80, 8'h80};
		tone_bass   = '{8'h80, 8'h80};
	endfunction

	// legacy alias: left high nibble, right high nibble moved down
	function automatic byte_t packed_view(byte_t l, byte_t r);
		return (l & 8'hf0) | (r >> 4);
	endfunction

	function automatic byte_t mixer_read(byte_t a, byte_t irq);
		case (a)
			ADDR_PK_DAC:    return packed_view(vol_dac[0], vol_dac[1]);
			ADDR_PK_MASTER: return packed_view(vol_master[0], vol_master[1]);
			ADDR_PK_FM:     return packed_view(vol_fm[0], vol_fm[1]);
			ADDR_PK_CD:     return packed_view(vol_cd[0], vol_cd[1]);
			ADDR_PK_LINE:   return packed_view(vol_line[0], vol_line[1]);
			ADDR_MASTER_L:  return vol_master[0];
			ADDR_MASTER_R:  return vol_master[1];
			ADDR_DAC_L:     return vol_dac[0];
			ADDR_DAC_R:     return vol_dac[1];
			ADDR_FM_L:      return vol_fm[0];
			ADDR_FM_R:      return vol_fm[1];
			ADDR_CD_L:      return vol_cd[0];
			ADDR_CD_R:      return vol_cd[1];
			ADDR_LINE_L:    return vol_line[0];
			ADDR_LINE_R:    return vol_line[1];
			ADDR_MIC:       return vol_mic;
			ADDR_SPEAKER:   return vol_spk;
			ADDR_OUT_SW:    return {3'b000, out_mix_sw};
			ADDR_IN_SW_L:   return {1'b0, in_mix_sw[0]};
			ADDR_IN_SW_R:   return {1'b0, in_mix_sw[1]};
			ADDR_IN_GAIN_L: return in_amp[0];
			ADDR_IN_GAIN_R: return in_amp[1];
			ADDR_OUT_GN_L:  return out_amp[0];
			ADDR_OUT_GN_R:  return out_amp[1];
			ADDR_AGC:       return {7'b0000000, agc_bit};
			ADDR_TREBLE_L:  return tone_treble[0];
			ADDR_TREBLE_R:  return tone_treble[1];
			ADDR_BASS_L:    return tone_bass[0];
			ADDR_BASS_R:    return tone_bass[1];
			ADDR_ID0:       return ID0_VALUE;
			ADDR_ID1:       return ID1_VALUE;
			ADDR_IRQ:       return irq;
			default:        return 8'h00;
		endcase
	endfunction

	function automatic void mixer_write(byte_t a, byte_t d);
		case (a)
			ADDR_RESET: begin
				if (!d[0]) begin
					load_mixer_defaults();
					n_restores++;
				end
			end
			ADDR_PK_DAC:    vol_dac    = '{{d[7:4], 4'h8}, {d[3:0], 4'h8}};
			ADDR_PK_MASTER: vol_master = '{{d[7:4], 4'h8}, {d[3:0], 4'h8}};
			ADDR_PK_FM:     vol_fm     = '{{d[7:4], 4'h8}, {d[3:0], 4'h8}};
			ADDR_PK_CD:     vol_cd     = '{{d[7:4], 4'h8}, {d[3:0], 4'h8}};
			ADDR_PK_LINE:   vol_line   = '{{d[7:4], 4'h8}, {d[3:0], 4'h8}};
			ADDR_MASTER_L:  vol_master[0] = d & 8'hf8;
			ADDR_MASTER_R:  vol_master[1] = d & 8'hf8;
			ADDR_DAC_L:     vol_dac[0] = d & 8'hf8;
			ADDR_DAC_R:     vol_dac[1] = d & 8'hf8;
			ADDR_FM_L:      vol_fm[0] = d & 8'hf8;
			ADDR_FM_R:      vol_fm[1] = d & 8'hf8;
			ADDR_CD_L:      vol_cd[0] = d & 8'hf8;
			ADDR_CD_R:      vol_cd[1] = d & 8'hf8;
			ADDR_LINE_L:    vol_line[0] = d & 8'hf8;
			ADDR_LINE_R:    vol_line[1] = d & 8'hf8;
			ADDR_MIC:       vol_mic = d & 8'hf8;
			ADDR_SPEAKER:   vol_spk = d & 8'hc0;
			ADDR_OUT_SW:    out_mix_sw = d[4:0];
			ADDR_IN_SW_L:   in_mix_sw[0] = d[6:0];
			ADDR_IN_SW_R:   in_mix_sw[1] = d[6:0];
			ADDR_IN_GAIN_L: in_amp[0] = d & 8'hc0;
			ADDR_IN_GAIN_R: in_amp[1] = d & 8'hc0;
			ADDR_OUT_GN_L:  out_amp[0] = d & 8'hc0;
			ADDR_OUT_GN_R:  out_amp[1] = d & 8'hc0;
			ADDR_AGC:       agc_bit = d[0];
			ADDR_TREBLE_L:  tone_treble[0] = d & 8'hf0;
			ADDR_TREBLE_R:  tone_treble[1] = d & 8'hf0;
			ADDR_BASS_L:    tone_bass[0] = d & 8'hf0;
			ADDR_BASS_R:    tone_bass[1] = d & 8'hf0;
			default: ;
		endcase
	endfunction

	function automatic byte_t predict_rdata(req_t r);
		byte_t rd;
		rd = 8'h00;
		if (r.op == OP_WRITE) begin
			if (r.port == PORT_DATA)
				mixer_write(sel_index, r.wdata);
			else
				sel_index = r.wdata;
		end else begin
			n_reads++;
			rd = (r.port == PORT_DATA) ? mixer_read(sel_index, r.irq_status) : sel_index;
		end
		return rd;
	endfunction

	function automatic byte_t rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic byte_t pick_address();
		if ($urandom_range(0, 4) == 0)
			return rand_byte();
		return known_addrs[$urandom_range(0, 32)];
	endfunction

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: stall pattern per phase, or one long hold-off on demand
	always @(negedge clk) begin
		rx_tick++;
		if (hold_off) begin
			rsp_ch.ready = 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_off = 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS:  rsp_ch.ready = 1'b1;
				RX_RANDOM:  rsp_ch.ready = 1'($urandom_range(0, 1));
				RX_PATTERN: rsp_ch.ready = (rx_tick % 5 != 0) && (rx_tick % 7 != 3);
				RX_SPARSE:  rsp_ch.ready = ($urandom_range(0, 3) == 0);
				default:    rsp_ch.ready = 1'b1;
			endcase
		end
	end

	// results are checked before the request of the same edge is predicted
	always @(posedge clk) begin
		byte_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_results++;
				if (expected_rdata.size() == 0) begin
					errors++;
					if (errors <= MAX_PRINTS)
						$display("%0t: result %02h with no request outstanding",
							$time, rsp_ch.data.rdata);
				end else begin
					want = expected_rdata.pop_front();
					if (rsp_ch.data.rdata !== want) begin
						errors++;
						if (errors <= MAX_PRINTS)
							$display("%0t: rdata expected %02h actual %02h",
								$time, want, rsp_ch.data.rdata);
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				n_requests++;
				expected_rdata.push_back(predict_rdata(req_ch.data));
			end
			if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin : watchdog
		wait (idle_cycles >= IDLE_LIMIT);
		$display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
		$display("audio_mixer_register_file_core: mismatch");
		$finish;
	end

	// called at a falling edge; returns at a falling edge, valid left high
	// unless the burst ended with a gap
	task automatic send_access(input logic acc_op, input logic acc_port,
			input byte_t acc_data, input byte_t acc_irq);
		int unsigned gap;
		req_ch.data  = '{op: acc_op, port: acc_port, wdata: acc_data, irq_status: acc_irq};
		req_ch.valid = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				req_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_for_results();
		req_ch.valid = 1'b0;
		while (expected_rdata.size() != 0) @(negedge clk);
	endtask

	task automatic test_index_port();
		send_access(OP_WRITE, PORT_INDEX, 8'hff, 8'h00);
		send_access(OP_READ, PORT_INDEX, 8'h00, 8'hff);
		send_access(OP_WRITE, PORT_INDEX, ADDR_RESET, 8'hff);
		send_access(OP_READ, PORT_INDEX, 8'hff, 8'h00);
		// register zero is write only
		send_access(OP_READ, PORT_DATA, 8'h00, 8'h00);
	endtask

	task automatic test_packed_alias();
		send_access(OP_WRITE, PORT_INDEX, ADDR_PK_DAC, 8'h00);
		send_access(OP_WRITE, PORT_DATA, 8'h0f, 8'h00);
		send_access(OP_READ, PORT_DATA, 8'h00, 8'h00);
		send_access(OP_WRITE, PORT_INDEX, ADDR_DAC_R, 8'h00);
		send_access(OP_READ, PORT_DATA, 8'h00, 8'h00);
		send_access(OP_WRITE, PORT_INDEX, ADDR_PK_CD, 8'h00);
		send_access(OP_READ, PORT_DATA, 8'h00, 8'h00);
	endtask

	// input switch and gains keep left at the odd address
	task automatic test_swapped_sides();
		send_access(OP_WRITE, PORT_INDEX, ADDR_IN_SW_L, 8'h00);
		send_access(OP_WRITE, PORT_DATA, 8'hff, 8'h00);
		send_access(OP_READ, PORT_DATA, 8'h00, 8'h00);
		send_access(OP_WRITE, PORT_INDEX, ADDR_IN_SW_R, 8'h00);
		send_access(OP_READ, PORT_DATA, 8'h00, 8'h00);
	endtask

	task automatic test_fixed_and_unmapped();
		send_access(OP_WRITE, PORT_INDEX, ADDR_IRQ, 8'h00);
		send_access(OP_READ, PORT_DATA, 8'h00, 8'hff);
		send_access(OP_WRITE, PORT_DATA, 8'h00, 8'h00);
		send_access(OP_READ, PORT_DATA, 8'h00, 8'h00);
		send_access(OP_WRITE, PORT_INDEX, 8'hff, 8'h00);
		send_access(OP_WRITE, PORT_DATA, 8'hff, 8'h00);
		send_access(OP_READ, PORT_DATA, 8'h00, 8'h00);
	endtask

	task automatic test_restore();
		send_access(OP_WRITE, PORT_INDEX, ADDR_RESET, 8'h00);
		send_access(OP_WRITE, PORT_DATA, 8'h01, 8'h00);
		send_access(OP_WRITE, PORT_DATA, 8'hfe, 8'h00);
		send_access(OP_WRITE, PORT_INDEX, ADDR_IN_SW_L, 8'h00);
		send_access(OP_READ, PORT_DATA, 8'h00, 8'h00);
	endtask

	// mostly index-then-data sequences, some index reads and raw noise
	task automatic test_random_traffic(input int unsigned count);
		int unsigned sent;
		int unsigned phase_end;
		int unsigned kind;
		int unsigned ops;
		sent = 0;
		phase_end = 0;
		while (sent < count) begin
			if (sent >= phase_end) begin
				if ($urandom_range(0, 2) == 0)
					wait_for_results();
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				case ($urandom_range(0, 2))
					0: gap_max = 0;
					1: gap_max = 3;
					default: gap_max = 10;
				endcase
				phase_end = sent + PHASE_ITEMS;
			end
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				send_access(OP_WRITE, PORT_INDEX, pick_address(), rand_byte());
				ops = $urandom_range(1, 3);
				for (int unsigned k = 0; k < ops; k++)
					send_access(1'($urandom_range(0, 1)), PORT_DATA, rand_byte(), rand_byte());
				sent += ops + 1;
			end else if (kind < 85) begin
				send_access(OP_READ, PORT_INDEX, rand_byte(), rand_byte());
				sent++;
			end else begin
				send_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					rand_byte(), rand_byte());
				sent++;
			end
		end
		wait_for_results();
	endtask

	// results held back while requests keep coming, so the input side stalls
	task automatic test_backpressure();
		rx_mode  = RX_ALWAYS;
		gap_max  = 0;
		hold_off = 1'b1;
		for (int unsigned k = 0; k < HELD_ITEMS; k += 2) begin
			send_access(OP_WRITE, PORT_INDEX, pick_address(), rand_byte());
			send_access(OP_READ, PORT_DATA, rand_byte(), rand_byte());
		end
		wait_for_results();
	endtask

	initial begin
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.data   = '0;
		rsp_ch.ready  = 1'b0;
		sel_index     = 8'h00;
		load_mixer_defaults();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_index_port();
		test_packed_alias();
		test_swapped_sides();
		test_fixed_and_unmapped();
		test_restore();
		wait_for_results();
		test_backpressure();
		test_random_traffic(RANDOM_ITEMS);

		wait_for_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("covered %0d requests (%0d reads) and %0d results, %0d register restores,",
			n_requests, n_reads, n_results, n_restores);
		$display("with receiver stalls, sender gaps and one long result hold-off");
		if (errors == 0 && expected_rdata.size() == 0)
			$display("audio_mixer_register_file_core: match");
		else
			$display("audio_mixer_register_file_core: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/amrf_pkg.sv
sv/amrf_req_if.sv
sv/amrf_rsp_if.sv
sv/amrf_regs.sv
sv/audio_mixer_register_file_core.sv
sv/amrf_chk.sv
bench/tb.sv
